>>> sv/sexp_pkg.sv
// shared types, character codes and helpers for the s-expression tokenizer
package sexp_pkg;

	localparam int BUF_BYTES_DEF = 64;

	typedef enum logic [1:0] {
		MODE_IDLE,
		MODE_TOKEN,
		MODE_COMMENT
	} scan_mode_t;

	typedef enum logic [2:0] {
		PH_START,
		PH_SIGNED,
		PH_ZERO,
		PH_HEXPFX,
		PH_DIGITS,
		PH_FAIL
	} num_phase_t;

	typedef enum logic [2:0] {
		KIND_END    = 3'd0,
		KIND_OPEN   = 3'd1,
		KIND_CLOSE  = 3'd2,
		KIND_QUOTE  = 3'd3,
		KIND_DOT    = 3'd4,
		KIND_NUMBER = 3'd5,
		KIND_SYMBOL = 3'd6,
		KIND_LONG   = 3'd7
	} tok_kind_t;

	typedef enum logic [1:0] {
		FIN_DOT,
		FIN_NUM,
		FIN_EMPTY,
		FIN_RUN
	} fin_type_t;

	typedef enum logic [2:0] {
		SQ_TAKE,
		SQ_FIN,
		SQ_RD,
		SQ_EMIT,
		SQ_TAIL
	} seq_state_t;

	localparam logic [4:0] RADIX_8  = 5'd8;
	localparam logic [4:0] RADIX_10 = 5'd10;
	localparam logic [4:0] RADIX_16 = 5'd16;

	typedef struct packed {
		num_phase_t  phase;
		logic        negative;
		logic [4:0]  radix;
		logic [63:0] accum;
		logic        overflow;
	} num_state_t;

	localparam num_state_t NUM_CLEAR = '{
		phase: PH_START, negative: 1'b0, radix: RADIX_10, accum: 64'd0, overflow: 1'b0
	};

	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_VT     = 8'h0B;
	localparam logic [7:0] CH_FF     = 8'h0C;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_QUOTE  = 8'h27;
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_PLUS   = 8'h2B;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_DOT    = 8'h2E;
	localparam logic [7:0] CH_D0     = 8'h30;
	localparam logic [7:0] CH_D1     = 8'h31;
	localparam logic [7:0] CH_D7     = 8'h37;
	localparam logic [7:0] CH_D9     = 8'h39;
	localparam logic [7:0] CH_SEMI   = 8'h3B;
	localparam logic [7:0] CH_UA     = 8'h41;
	localparam logic [7:0] CH_UF     = 8'h46;
	localparam logic [7:0] CH_UX     = 8'h58;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_LA     = 8'h61;
	localparam logic [7:0] CH_LF_HEX = 8'h66;
	localparam logic [7:0] CH_LX     = 8'h78;
	localparam logic [7:0] CH_BAR    = 8'h7C;

	function automatic logic is_space(input logic [7:0] c);
		return c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_VT ||
			c == CH_FF || c == CH_CR;
	endfunction

	function automatic logic is_symchar(input logic [7:0] c);
		return !is_space(c) && c != CH_LPAREN && c != CH_RPAREN && c != CH_QUOTE &&
			c != CH_SEMI && c != CH_BSLASH && c != CH_BAR;
	endfunction

endpackage

>>> sv/sexp_ram.sv
// generic single-port-write, registered-read ram
module sexp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

>>> sv/sexp_num.sv
// number unit: one digit step of the integer parse and the saturated result
module sexp_num (
	input  logic [7:0]           ch,
	input  sexp_pkg::num_state_t cur,
	output sexp_pkg::num_state_t nxt,
	output logic [63:0]          value
);

	logic [4:0]  dval;
	logic        dok;
	logic [4:0]  mul_radix;
	logic [67:0] prod;
	logic [67:0] sum;
	logic        ovf_step;
	logic        add;

	// digit value, hex letters included
	always_comb begin
		dok = 1'b1;
		dval = 5'd0;
		if (ch >= sexp_pkg::CH_D0 && ch <= sexp_pkg::CH_D9) begin
			dval = 5'(ch - sexp_pkg::CH_D0);
		end else if (ch >= sexp_pkg::CH_LA && ch <= sexp_pkg::CH_LF_HEX) begin
			dval = 5'(ch - sexp_pkg::CH_LA) + 5'd10;
		end else if (ch >= sexp_pkg::CH_UA && ch <= sexp_pkg::CH_UF) begin
			dval = 5'(ch - sexp_pkg::CH_UA) + 5'd10;
		end else begin
			dok = 1'b0;
		end
	end

	always_comb begin
		case (cur.phase)
			sexp_pkg::PH_START, sexp_pkg::PH_SIGNED: mul_radix = sexp_pkg::RADIX_10;
			sexp_pkg::PH_ZERO: mul_radix = sexp_pkg::RADIX_8;
			default: mul_radix = cur.radix;
		endcase
	end

	// radix is 8, 10 or 16, so the product is shifts and one add
	always_comb begin
		case (mul_radix)
			sexp_pkg::RADIX_8:  prod = {1'b0, cur.accum, 3'b000};
			sexp_pkg::RADIX_16: prod = {cur.accum, 4'b0000};
			default: prod = {1'b0, cur.accum, 3'b000} + {3'b000, cur.accum, 1'b0};
		endcase
		sum = prod + 68'(dval);
		ovf_step = |sum[67:64];
	end

	always_comb begin
		nxt = cur;
		add = 1'b0;
		case (cur.phase)
			sexp_pkg::PH_START, sexp_pkg::PH_SIGNED: begin
				if (cur.phase == sexp_pkg::PH_START &&
					(ch == sexp_pkg::CH_PLUS || ch == sexp_pkg::CH_MINUS)) begin
					nxt.negative = (ch == sexp_pkg::CH_MINUS);
					nxt.phase = sexp_pkg::PH_SIGNED;
				end else if (ch == sexp_pkg::CH_D0) begin
					nxt.phase = sexp_pkg::PH_ZERO;
				end else if (ch >= sexp_pkg::CH_D1 && ch <= sexp_pkg::CH_D9) begin
					nxt.radix = sexp_pkg::RADIX_10;
					add = 1'b1;
				end else begin
					nxt.phase = sexp_pkg::PH_FAIL;
				end
			end
			sexp_pkg::PH_ZERO: begin
				if (ch == sexp_pkg::CH_LX || ch == sexp_pkg::CH_UX) begin
					nxt.radix = sexp_pkg::RADIX_16;
					nxt.phase = sexp_pkg::PH_HEXPFX;
				end else if (ch >= sexp_pkg::CH_D0 && ch <= sexp_pkg::CH_D7) begin
					nxt.radix = sexp_pkg::RADIX_8;
					add = 1'b1;
				end else begin
					nxt.phase = sexp_pkg::PH_FAIL;
				end
			end
			sexp_pkg::PH_HEXPFX, sexp_pkg::PH_DIGITS: begin
				if (dok && dval < cur.radix) begin
					add = 1'b1;
				end else begin
					nxt.phase = sexp_pkg::PH_FAIL;
				end
			end
			default: nxt.phase = sexp_pkg::PH_FAIL;
		endcase
		if (add) begin
			nxt.phase = sexp_pkg::PH_DIGITS;
			if (ovf_step) begin
				nxt.overflow = 1'b1;
			end else begin
				nxt.accum = sum[63:0];
			end
		end
	end

	// saturated signed result of the current accumulator
	always_comb begin
		if (cur.negative) begin
			if (cur.overflow || (cur.accum[63] && |cur.accum[62:0])) begin
				value = {1'b1, 63'd0};
			end else begin
				value = 64'd0 - cur.accum;
			end
		end else begin
			if (cur.overflow || cur.accum[63]) begin
				value = {1'b0, {63{1'b1}}};
			end else begin
				value = cur.accum;
			end
		end
	end

endmodule

>>> sv/s_expression_tokenizer_top.sv
// s-expression tokenizer top level: scanner state, token buffer and result sequencer
//
// Takes one text byte per word on the ch channel (byte 0 is end of input) and
// produces token words on the tok channel; last marks the final word caused by
// one input byte. Whitespace and ';' comments are skipped, ( ) ' give single
// words, '|' pairs and '\' escape token characters, a lone '.' is a dot, and a
// token starting with a digit or sign that parses as a C base-0 integer comes
// out as one number word saturated to 64 bits. Any other token is read back
// from the token buffer ram and sent as one symbol-character word per
// character; an empty token gives one symbol word with char 0. A token that
// reaches BUF_BYTES-1 characters gives a too-long word and is dropped.
// Sequence: a byte that completes nothing or gives a single word is taken
// directly in SQ_TAKE. A finished number, dot or empty symbol passes SQ_FIN,
// a symbol run passes SQ_RD (ram read) then SQ_EMIT (output load) for each
// character, and a following delimiter or end word adds SQ_TAIL. Bytes are
// taken again once the run is done. Writes into the buffer happen only while
// bytes are taken and reads only while a run is sent, so the two never
// collide. The output register holds each word while tok_stall is high, and
// no byte is taken until it can load again.
module s_expression_tokenizer_top #(
	parameter int BUF_BYTES = sexp_pkg::BUF_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        ch_valid,
	output logic        ch_stall,
	input  logic [7:0]  ch,
	output logic        tok_valid,
	input  logic        tok_stall,
	output logic [2:0]  tok_kind,
	output logic [63:0] num_value,
	output logic [7:0]  sym_char,
	output logic        last
);

	localparam int AW = $clog2(BUF_BYTES);

	// scanner state
	sexp_pkg::scan_mode_t mode_q, mode_n;
	logic                 bar_q, bar_n;
	logic                 esc_q, esc_n;
	logic                 dot_q, dot_n;
	logic [1:0]           rc_q, rc_n;
	logic                 nstart_q, nstart_n;
	sexp_pkg::num_state_t num_q, num_n, num_cur, num_step;
	logic [AW-1:0]        len_q, len_n;
	logic [63:0]          num_sat;

	// scan decisions for the current byte
	logic                 start_tok;
	logic                 direct_v;
	sexp_pkg::tok_kind_t  direct_kind;
	logic                 fin;
	sexp_pkg::fin_type_t  fin_type;
	logic                 tail_v;
	sexp_pkg::tok_kind_t  tail_kind;
	logic                 wr_en;
	logic [AW-1:0]        wr_addr;
	logic [AW:0]          len_inc;

	// sequencer
	sexp_pkg::seq_state_t state_q, state_n;
	sexp_pkg::fin_type_t  fin_type_q;
	logic [63:0]          fin_val_q;
	logic                 tail_v_q;
	sexp_pkg::tok_kind_t  tail_kind_q;
	logic [AW-1:0]        run_len_q;
	logic [AW-1:0]        run_idx_q;
	logic                 run_end;
	logic                 rd_en;
	logic [7:0]           rd_data;
	logic                 accept;
	logic                 out_free;

	// output register
	logic                 tok_valid_q;
	sexp_pkg::tok_kind_t  kind_q;
	logic [63:0]          val_q;
	logic [7:0]           sym_q;
	logic                 last_q;
	logic                 load;
	sexp_pkg::tok_kind_t  ld_kind;
	logic [63:0]          ld_val;
	logic [7:0]           ld_sym;
	logic                 ld_last;

	sexp_ram #(
		.WIDTH(8),
		.DEPTH(BUF_BYTES)
	) u_buf (
		.clk  (clk),
		.we   (wr_en),
		.waddr(wr_addr),
		.wdata(ch),
		.re   (rd_en),
		.raddr(run_idx_q),
		.rdata(rd_data)
	);

	// a fresh token starts from cleared number state
	assign num_cur = start_tok ? sexp_pkg::NUM_CLEAR : num_q;

	sexp_num u_num (
		.ch   (ch),
		.cur  (num_cur),
		.nxt  (num_step),
		.value(num_sat)
	);

	assign out_free = !tok_valid_q || !tok_stall;
	assign ch_stall = !(state_q == sexp_pkg::SQ_TAKE && out_free);
	assign accept = ch_valid && !ch_stall;

	assign start_tok = mode_q == sexp_pkg::MODE_IDLE && ch != sexp_pkg::CH_NUL &&
		!sexp_pkg::is_space(ch) && ch != sexp_pkg::CH_LPAREN &&
		ch != sexp_pkg::CH_RPAREN && ch != sexp_pkg::CH_QUOTE && ch != sexp_pkg::CH_SEMI;

	// next scanner state and what this byte emits
	always_comb begin
		logic t_bar, t_esc;
		logic [1:0] t_rc;
		logic [AW-1:0] t_len;
		logic acc, r_delim, r_end, clr;

		mode_n = mode_q;
		bar_n = bar_q;
		esc_n = esc_q;
		dot_n = dot_q;
		rc_n = rc_q;
		nstart_n = nstart_q;
		num_n = num_q;
		len_n = len_q;
		direct_v = 1'b0;
		direct_kind = sexp_pkg::KIND_END;
		fin = 1'b0;
		fin_type = sexp_pkg::FIN_RUN;
		tail_v = 1'b0;
		tail_kind = sexp_pkg::KIND_END;
		wr_en = 1'b0;
		acc = 1'b0;
		r_delim = 1'b0;
		r_end = 1'b0;
		clr = 1'b0;

		t_bar = start_tok ? 1'b0 : bar_q;
		t_esc = start_tok ? 1'b0 : esc_q;
		t_rc = start_tok ? 2'd0 : rc_q;
		t_len = start_tok ? '0 : len_q;
		wr_addr = t_len;
		len_inc = {1'b0, t_len} + 1'b1;

		case (mode_q)
			sexp_pkg::MODE_COMMENT: begin
				if (ch == sexp_pkg::CH_NUL) begin
					direct_v = 1'b1;
					mode_n = sexp_pkg::MODE_IDLE;
				end else if (ch == sexp_pkg::CH_LF) begin
					mode_n = sexp_pkg::MODE_IDLE;
				end
			end
			sexp_pkg::MODE_TOKEN: begin
			end
			default: begin
				if (ch == sexp_pkg::CH_NUL) begin
					direct_v = 1'b1;
				end else if (ch == sexp_pkg::CH_LPAREN) begin
					direct_v = 1'b1;
					direct_kind = sexp_pkg::KIND_OPEN;
				end else if (ch == sexp_pkg::CH_RPAREN) begin
					direct_v = 1'b1;
					direct_kind = sexp_pkg::KIND_CLOSE;
				end else if (ch == sexp_pkg::CH_QUOTE) begin
					direct_v = 1'b1;
					direct_kind = sexp_pkg::KIND_QUOTE;
				end else if (ch == sexp_pkg::CH_SEMI) begin
					mode_n = sexp_pkg::MODE_COMMENT;
				end else if (start_tok) begin
					mode_n = sexp_pkg::MODE_TOKEN;
					dot_n = (ch == sexp_pkg::CH_DOT);
					nstart_n = (ch >= sexp_pkg::CH_D0 && ch <= sexp_pkg::CH_D9) ||
						ch == sexp_pkg::CH_PLUS || ch == sexp_pkg::CH_MINUS;
					bar_n = 1'b0;
					esc_n = 1'b0;
					rc_n = 2'd0;
					num_n = sexp_pkg::NUM_CLEAR;
					len_n = '0;
				end
			end
		endcase

		// one token character
		if (mode_q == sexp_pkg::MODE_TOKEN || start_tok) begin
			if (t_esc) begin
				esc_n = 1'b0;
				if (ch == sexp_pkg::CH_NUL) begin
					r_end = 1'b1;
				end else begin
					acc = 1'b1;
				end
			end else begin
				rc_n = (t_rc == 2'd3) ? t_rc : t_rc + 2'd1;
				if (ch == sexp_pkg::CH_NUL) begin
					r_end = 1'b1;
				end else if (ch == sexp_pkg::CH_BAR) begin
					bar_n = !t_bar;
				end else if (ch == sexp_pkg::CH_BSLASH) begin
					esc_n = 1'b1;
				end else if (!t_bar && !sexp_pkg::is_symchar(ch)) begin
					r_delim = 1'b1;
				end else begin
					acc = 1'b1;
				end
			end
		end

		if (acc) begin
			wr_en = accept;
			len_n = len_inc[AW-1:0];
			num_n = num_step;
			if (len_inc >= (AW+1)'(BUF_BYTES - 1)) begin
				direct_v = 1'b1;
				direct_kind = sexp_pkg::KIND_LONG;
				clr = 1'b1;
			end
		end

		// token finished: classify it from the state it built up
		if (r_delim || r_end) begin
			fin = 1'b1;
			clr = 1'b1;
			if (dot_q && rc_n == 2'd2) begin
				fin_type = sexp_pkg::FIN_DOT;
			end else if (nstart_q && (num_q.phase == sexp_pkg::PH_ZERO ||
				num_q.phase == sexp_pkg::PH_DIGITS)) begin
				fin_type = sexp_pkg::FIN_NUM;
			end else if (len_q == '0) begin
				fin_type = sexp_pkg::FIN_EMPTY;
			end else begin
				fin_type = sexp_pkg::FIN_RUN;
			end
		end

		if (clr) begin
			mode_n = sexp_pkg::MODE_IDLE;
			bar_n = 1'b0;
			esc_n = 1'b0;
			dot_n = 1'b0;
			rc_n = 2'd0;
			nstart_n = 1'b0;
			num_n = sexp_pkg::NUM_CLEAR;
			len_n = '0;
		end

		// the delimiter or end that closed the token, handled between tokens
		if (r_end) begin
			tail_v = 1'b1;
		end else if (r_delim) begin
			if (ch == sexp_pkg::CH_LPAREN) begin
				tail_v = 1'b1;
				tail_kind = sexp_pkg::KIND_OPEN;
			end else if (ch == sexp_pkg::CH_RPAREN) begin
				tail_v = 1'b1;
				tail_kind = sexp_pkg::KIND_CLOSE;
			end else if (ch == sexp_pkg::CH_QUOTE) begin
				tail_v = 1'b1;
				tail_kind = sexp_pkg::KIND_QUOTE;
			end else if (ch == sexp_pkg::CH_SEMI) begin
				mode_n = sexp_pkg::MODE_COMMENT;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= sexp_pkg::MODE_IDLE;
			bar_q <= 1'b0;
			esc_q <= 1'b0;
			dot_q <= 1'b0;
			rc_q <= 2'd0;
			nstart_q <= 1'b0;
			num_q <= sexp_pkg::NUM_CLEAR;
			len_q <= '0;
		end else if (accept) begin
			mode_q <= mode_n;
			bar_q <= bar_n;
			esc_q <= esc_n;
			dot_q <= dot_n;
			rc_q <= rc_n;
			nstart_q <= nstart_n;
			num_q <= num_n;
			len_q <= len_n;
		end
	end

	assign run_end = run_idx_q == run_len_q - 1'b1;

	// sequencer: next state and output loads
	always_comb begin
		state_n = state_q;
		load = 1'b0;
		ld_kind = sexp_pkg::KIND_END;
		ld_val = 64'd0;
		ld_sym = 8'd0;
		ld_last = 1'b1;
		rd_en = 1'b0;
		case (state_q)
			sexp_pkg::SQ_TAKE: begin
				if (accept) begin
					if (direct_v) begin
						load = 1'b1;
						ld_kind = direct_kind;
					end
					if (fin) begin
						state_n = (fin_type == sexp_pkg::FIN_RUN) ?
							sexp_pkg::SQ_RD : sexp_pkg::SQ_FIN;
					end
				end
			end
			sexp_pkg::SQ_FIN: begin
				if (out_free) begin
					load = 1'b1;
					ld_last = !tail_v_q;
					case (fin_type_q)
						sexp_pkg::FIN_DOT: ld_kind = sexp_pkg::KIND_DOT;
						sexp_pkg::FIN_NUM: begin
							ld_kind = sexp_pkg::KIND_NUMBER;
							ld_val = fin_val_q;
						end
						default: ld_kind = sexp_pkg::KIND_SYMBOL;
					endcase
					state_n = tail_v_q ? sexp_pkg::SQ_TAIL : sexp_pkg::SQ_TAKE;
				end
			end
			sexp_pkg::SQ_RD: begin
				rd_en = 1'b1;
				state_n = sexp_pkg::SQ_EMIT;
			end
			sexp_pkg::SQ_EMIT: begin
				if (out_free) begin
					load = 1'b1;
					ld_kind = sexp_pkg::KIND_SYMBOL;
					ld_sym = rd_data;
					ld_last = run_end && !tail_v_q;
					if (run_end) begin
						state_n = tail_v_q ? sexp_pkg::SQ_TAIL : sexp_pkg::SQ_TAKE;
					end else begin
						state_n = sexp_pkg::SQ_RD;
					end
				end
			end
			sexp_pkg::SQ_TAIL: begin
				if (out_free) begin
					load = 1'b1;
					ld_kind = tail_kind_q;
					state_n = sexp_pkg::SQ_TAKE;
				end
			end
			default: state_n = sexp_pkg::SQ_TAKE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sexp_pkg::SQ_TAKE;
		end else begin
			state_q <= state_n;
		end
	end

	// finish context, captured when a token closes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tail_v_q <= 1'b0;
			run_idx_q <= '0;
			run_len_q <= '0;
		end else if (accept && fin) begin
			tail_v_q <= tail_v;
			run_idx_q <= '0;
			run_len_q <= len_q;
		end else if (state_q == sexp_pkg::SQ_EMIT && out_free) begin
			run_idx_q <= run_idx_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && fin) begin
			fin_type_q <= fin_type;
			fin_val_q <= num_sat;
			tail_kind_q <= tail_kind;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_valid_q <= 1'b0;
		end else begin
			tok_valid_q <= load || (tok_valid_q && tok_stall);
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			kind_q <= ld_kind;
			val_q <= ld_val;
			sym_q <= ld_sym;
			last_q <= ld_last;
		end
	end

	assign tok_valid = tok_valid_q;
	assign tok_kind = kind_q;
	assign num_value = val_q;
	assign sym_char = sym_q;
	assign last = last_q;

`ifndef SYNTH
	// a symbol run never reads past the characters gathered
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == sexp_pkg::SQ_EMIT |-> run_idx_q < run_len_q)
		else $error("symbol run index past token length");

	// the buffer is dropped before it can overflow
	assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, len_q} <= (AW+1)'(BUF_BYTES - 2))
		else $error("token length beyond buffer limit");

	// outside a token no characters stay gathered
	assert property (@(posedge clk) disable iff (!arst_n)
		mode_q != sexp_pkg::MODE_TOKEN |-> len_q == '0)
		else $error("token length left over outside a token");

	// the trailing word is only sent when one was captured
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == sexp_pkg::SQ_TAIL |-> tail_v_q)
		else $error("tail state without a pending word");
`endif

endmodule
